// ----- rtl/core/trapezoid_position_profile_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the trapezoid position profile core
// Each macro wraps one concurrent assertion clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef TRAPEZOID_POSITION_PROFILE_CORE_ASSERT_SVH
`define TRAPEZOID_POSITION_PROFILE_CORE_ASSERT_SVH

// Generic property, reset disables the attempt.
`define TPP_ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define TPP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/tpp_pkg.sv -----
// ----------------------------------------------------------------------------
// tpp_pkg
// Types and constants shared by the trapezoid position profile core.
// ----------------------------------------------------------------------------
package tpp_pkg;

   localparam int POS_BITS  = 32;
   localparam int FRAC_BITS = 16;
   localparam int PLAN_W    = POS_BITS + FRAC_BITS + 1;   // planned position
   localparam int DIFF_W    = PLAN_W + 1;                 // distance to target
   localparam int SPEED_W   = 24;
   localparam int ACCEL_W   = 20;
   localparam int VEL_W     = SPEED_W + 2;

   // digit-serial multiplier
   localparam int DIGIT_W   = 4;
   localparam int MUL_STEPS = (SPEED_W + DIGIT_W - 1) / DIGIT_W;
   localparam int STEP_CW   = $clog2(MUL_STEPS);
   localparam int DMAG_W    = 2 * SPEED_W;                // clamped |distance|
   localparam int VSQ_W     = 2 * SPEED_W;
   localparam int PROD_W    = ACCEL_W + DMAG_W;

   localparam logic [SPEED_W-1:0] SPEED_RESET = 24'd5315022;
   localparam logic [ACCEL_W-1:0] ACCEL_RESET = 20'd5154;

   // stream payload layout
   localparam int REQ_W    = 72;
   localparam int RSP_W    = 40;
   localparam int TGT_LSB  = 0;
   localparam int ACT_LSB  = POS_BITS;
   localparam int EN_BIT   = 2 * POS_BITS;
   localparam int MOV_BIT  = POS_BITS;

   localparam int CSR_AW   = 1;
   localparam int CSR_DW   = SPEED_W;

   typedef enum logic [CSR_AW-1:0] {
      CSR_SPEED_LIMIT = 1'b0,
      CSR_ACCEL_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MUL,
      ST_STEP,
      ST_MOVE,
      ST_SNAP,
      ST_OUT
   } state_type;

endpackage

// ----- rtl/core/trapezoid_position_profile_core.sv -----
// ----------------------------------------------------------------------------
// trapezoid_position_profile_core
// Bang-bang phase-plane position planner, one planned position per item.
// Planning item: runs through DIFF, the radix-16 digit-serial multiplier
//   (MUL) that forms v*v and a*|D|, then STEP, MOVE, SNAP and OUT.
// Bypassed or already-aligned item: goes from DIFF straight to OUT.
// One item in work at a time; a finished result waits in OUT on rsp_tready.
// Synchronous reset: planner idle, limits back to their defaults.
// ----------------------------------------------------------------------------
module trapezoid_position_profile_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // [31:0] target_position, [63:32] actual_position, [64] profile_enable
   input  logic [tpp_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [31:0] planned_position, [32] moving
   output logic [tpp_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                        csr_we,
   input  logic [tpp_pkg::CSR_AW-1:0]  csr_addr,
   input  logic [tpp_pkg::CSR_DW-1:0]  csr_wdata
);
   import tpp_pkg::*;

   localparam int EXT_W = PLAN_W - POS_BITS - FRAC_BITS;
   localparam int QQ_W  = PLAN_W - FRAC_BITS;

   state_type state_ff, state_in;

   logic [SPEED_W-1:0]  speed_ff;
   logic [ACCEL_W-1:0]  accel_ff;
   logic                active_ff;
   logic                rsp_valid_ff;
   logic [RSP_W-1:0]    rsp_data_ff;

   logic [POS_BITS-1:0] target_ff, actual_ff;
   logic                enable_ff;
   logic                pass_ff;
   logic [PLAN_W-1:0]   plan_pos_ff;
   logic [VEL_W-1:0]    plan_vel_ff;
   logic                d_neg_ff, d_zero_ff;
   logic [DMAG_W-1:0]   dmag_ff;
   logic [SPEED_W-1:0]  vmag_ff, vdig_ff, adig_ff;
   logic [VSQ_W-1:0]    vsq_ff;
   logic [PROD_W-1:0]   ad_ff;
   logic [STEP_CW-1:0]  cnt_ff;

   logic rsp_free, rsp_load;

   // ---------------- distance and anchoring ----------------
   logic [DIFF_W-1:0]  tq_w, base_x, d_fwd, d_rev, d_mag;
   logic [PLAN_W-1:0]  anchor, base_w;
   logic [VEL_W-1:0]   vel_base, vel_neg;
   logic               aligned, d_neg;

   assign tq_w   = {{(EXT_W + 1){target_ff[POS_BITS-1]}}, target_ff, {FRAC_BITS{1'b0}}};
   assign anchor = {{EXT_W{actual_ff[POS_BITS-1]}}, actual_ff, {FRAC_BITS{1'b0}}};
   assign base_w = active_ff ? plan_pos_ff : anchor;
   assign base_x = {base_w[PLAN_W-1], base_w};
   // both directions in parallel, the sign picks one
   assign d_fwd  = tq_w - base_x;
   assign d_rev  = base_x - tq_w;
   assign d_neg  = d_fwd[DIFF_W-1];
   assign d_mag  = d_neg ? d_rev : d_fwd;
   assign aligned = !active_ff && (target_ff == actual_ff);

   assign vel_base = active_ff ? plan_vel_ff : '0;
   assign vel_neg  = -vel_base;

   // ---------------- digit-serial products ----------------
   logic [DIGIT_W-1:0]          vtop, atop;
   logic [SPEED_W+DIGIT_W-1:0]  vpart;
   logic [DMAG_W+DIGIT_W-1:0]   apart;

   assign vtop  = vdig_ff[SPEED_W-1 -: DIGIT_W];
   assign atop  = adig_ff[SPEED_W-1 -: DIGIT_W];
   assign vpart = vmag_ff * vtop;
   assign apart = dmag_ff * atop;

   // ---------------- velocity step ----------------
   logic             beyond, d_pos, v_neg, v_pos, v_up, v_dn;
   logic [VEL_W-1:0] a_ext, vmax_ext, vsum, vclamp;

   assign beyond = {ad_ff, 1'b0} > {{(PROD_W + 1 - VSQ_W){1'b0}}, vsq_ff};
   assign d_pos  = !d_neg_ff && !d_zero_ff;
   assign v_neg  = plan_vel_ff[VEL_W-1];
   assign v_pos  = !v_neg && (plan_vel_ff != '0);
   assign v_up   = (d_pos && (v_neg || beyond)) || (d_neg_ff && !(v_pos || beyond))
                   || (d_zero_ff && v_neg);
   assign v_dn   = (d_pos && !(v_neg || beyond)) || (d_neg_ff && (v_pos || beyond))
                   || (d_zero_ff && v_pos);
   assign a_ext    = {{(VEL_W - ACCEL_W){1'b0}}, accel_ff};
   assign vmax_ext = {{(VEL_W - SPEED_W){1'b0}}, speed_ff};

   always_comb begin
      priority if (v_up) begin
         vsum = plan_vel_ff + a_ext;
      end else if (v_dn) begin
         vsum = plan_vel_ff - a_ext;
      end else begin
         vsum = plan_vel_ff;
      end
      priority if ($signed(vsum) > $signed(vmax_ext)) begin
         vclamp = vmax_ext;
      end else if ($signed(vsum) < -$signed(vmax_ext)) begin
         vclamp = -vmax_ext;
      end else begin
         vclamp = vsum;
      end
   end

   // ---------------- position step and snap ----------------
   logic [PLAN_W:0]    psum;
   logic [PLAN_W-1:0]  psat;
   logic [DIFF_W-1:0]  rem;
   logic [VEL_W-1:0]   vabs;
   logic               rem_small, slow, snap;

   assign psum = {plan_pos_ff[PLAN_W-1], plan_pos_ff}
                 + {{(PLAN_W + 1 - VEL_W){plan_vel_ff[VEL_W-1]}}, plan_vel_ff};
   assign psat = (psum[PLAN_W] != psum[PLAN_W-1])
                 ? {psum[PLAN_W], {(PLAN_W - 1){~psum[PLAN_W]}}} : psum[PLAN_W-1:0];

   assign rem  = tq_w - {plan_pos_ff[PLAN_W-1], plan_pos_ff};
   // |rem| below one whole LSB: upper bits all zero, or all one with a nonzero fraction
   assign rem_small = (rem[DIFF_W-1:FRAC_BITS] == '0)
                      || ((&rem[DIFF_W-1:FRAC_BITS]) && (rem[FRAC_BITS-1:0] != '0));
   assign vabs = plan_vel_ff[VEL_W-1] ? -plan_vel_ff : plan_vel_ff;
   assign slow = vabs < a_ext;
   assign snap = rem_small && slow;

   // ---------------- result: truncate toward zero, saturate ----------------
   logic [PLAN_W-1:0]   qsum;
   logic [QQ_W-1:0]     qq;
   logic [POS_BITS-1:0] qsat, out_pos;

   assign qsum = plan_pos_ff
                 + {{(PLAN_W - FRAC_BITS){1'b0}}, {FRAC_BITS{plan_pos_ff[PLAN_W-1]}}};
   assign qq   = qsum[PLAN_W-1:FRAC_BITS];
   assign qsat = (qq[QQ_W-1] != qq[QQ_W-2])
                 ? {qq[QQ_W-1], {(POS_BITS - 1){~qq[QQ_W-1]}}} : qq[POS_BITS-1:0];
   assign out_pos = pass_ff ? target_ff : qsat;

   // ---------------- control ----------------
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_DIFF;
         ST_DIFF: state_in = (!enable_ff || aligned) ? ST_OUT : ST_MUL;
         ST_MUL:  if (cnt_ff == STEP_CW'(MUL_STEPS - 1)) state_in = ST_STEP;
         ST_STEP: state_in = ST_MOVE;
         ST_MOVE: state_in = ST_SNAP;
         ST_SNAP: state_in = ST_OUT;
         ST_OUT:  if (rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_load   = (state_ff == ST_OUT) && rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         speed_ff     <= SPEED_RESET;
         accel_ff     <= ACCEL_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_addr))
               CSR_SPEED_LIMIT: speed_ff <= csr_wdata;
               CSR_ACCEL_LIMIT: accel_ff <= csr_wdata[ACCEL_W-1:0];
            endcase
         end
         if (state_ff == ST_DIFF) begin
            active_ff <= enable_ff && !aligned;
         end else if (state_ff == ST_SNAP && snap) begin
            active_ff <= 1'b0;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               target_ff <= req_tdata[TGT_LSB +: POS_BITS];
               actual_ff <= req_tdata[ACT_LSB +: POS_BITS];
               enable_ff <= req_tdata[EN_BIT];
            end
         end
         ST_DIFF: begin
            if (!enable_ff) begin
               plan_vel_ff <= '0;
               pass_ff     <= 1'b1;
            end else if (aligned) begin
               plan_pos_ff <= anchor;
               plan_vel_ff <= '0;
               pass_ff     <= 1'b1;
            end else begin
               plan_pos_ff <= base_w;
               plan_vel_ff <= vel_base;
               pass_ff     <= 1'b0;
               d_neg_ff    <= d_neg;
               d_zero_ff   <= (d_fwd == '0);
               // any distance this far is beyond braking for a nonzero accel
               dmag_ff     <= (d_mag[DIFF_W-1:DMAG_W] != '0) ? '1 : d_mag[DMAG_W-1:0];
               vmag_ff     <= vel_base[VEL_W-1] ? vel_neg[SPEED_W-1:0]
                                                : vel_base[SPEED_W-1:0];
               vdig_ff     <= vel_base[VEL_W-1] ? vel_neg[SPEED_W-1:0]
                                                : vel_base[SPEED_W-1:0];
               adig_ff     <= {{(SPEED_W - ACCEL_W){1'b0}}, accel_ff};
               vsq_ff      <= '0;
               ad_ff       <= '0;
               cnt_ff      <= '0;
            end
         end
         ST_MUL: begin
            vsq_ff  <= (vsq_ff << DIGIT_W) + VSQ_W'(vpart);
            ad_ff   <= (ad_ff << DIGIT_W) + PROD_W'(apart);
            vdig_ff <= vdig_ff << DIGIT_W;
            adig_ff <= adig_ff << DIGIT_W;
            cnt_ff  <= cnt_ff + 1'b1;
         end
         ST_STEP: plan_vel_ff <= vclamp;
         ST_MOVE: plan_pos_ff <= psat;
         ST_SNAP: begin
            if (snap) begin
               plan_pos_ff <= tq_w[PLAN_W-1:0];
               plan_vel_ff <= '0;
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               rsp_data_ff <= {{(RSP_W - POS_BITS - 1){1'b0}}, active_ff, out_pos};
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/core/tpp_checker.sv -----
// ----------------------------------------------------------------------------
// tpp_checker
// Port-level checks on the trapezoid position profile core, bound to the top.
// ----------------------------------------------------------------------------
`include "trapezoid_position_profile_core_assert.svh"

module tpp_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   // [31:0] target_position, [63:32] actual_position, [64] profile_enable
   input logic [tpp_pkg::REQ_W-1:0]  req_tdata,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   // [31:0] planned_position, [32] moving
   input logic [tpp_pkg::RSP_W-1:0]  rsp_tdata
);
   import tpp_pkg::*;

   // stalled result holds
   `TPP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // one item in work at a time
   `TPP_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "ready right after accepting an item")

   // a result only shows up after the block was busy with an item
   `TPP_ASSERT_PROP(a_rsp_after_work, clock, reset, $rose(rsp_tvalid) |-> $past(!req_tready), "result without an item in work")

   // bypassed item returns its target, not moving, once it is through DIFF and OUT
   `TPP_ASSERT_PROP(a_bypass, clock, reset, (req_tvalid && req_tready && !req_tdata[EN_BIT] && !rsp_tvalid) |-> ##3 (rsp_tvalid && !rsp_tdata[MOV_BIT] && (rsp_tdata[POS_BITS-1:0] == $past(req_tdata[TGT_LSB +: POS_BITS], 3))), "bypass result wrong")

endmodule

bind trapezoid_position_profile_core tpp_checker u_tpp_checker (.*);
